@@ design/erm_pkg.sv @@
package erm_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 6;
	localparam int OUT_FRAC_BITS_DEF = 14;

	// internal fixed point: Q30
	localparam int QF = 30;
	localparam longint unsigned Q_ONE = 64'd1 << QF;
	localparam longint unsigned Q_HALF = 64'd1 << (QF - 1);
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	localparam int SERIES_LEVELS = 7;

	// pipeline depths
	localparam int PHASE_LAT = 6;
	localparam int LANE_LAT = PHASE_LAT + 4 + 2 * SERIES_LEVELS;
	localparam int MERGE_LAT = 6;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

	typedef logic signed [31:0] q30_t;

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] m_r0_c0;
		logic signed [15:0] m_r0_c1;
		logic signed [15:0] m_r0_c2;
		logic signed [15:0] m_r1_c0;
		logic signed [15:0] m_r1_c1;
		logic signed [15:0] m_r1_c2;
		logic signed [15:0] m_r2_c0;
		logic signed [15:0] m_r2_c1;
		logic signed [15:0] m_r2_c2;
	} matrix_t;

	// octant fold info carried alongside the series
	typedef struct packed {
		logic [1:0] quad;
		logic       swap;
	} octant_t;

endpackage

@@ design/erm_phase.sv @@
module erm_phase #(
	parameter int ANGLE_FRAC_BITS = erm_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic signed [15:0] angle,
	output logic [29:0]        x_s6,
	output erm_pkg::octant_t   oct_s6
);
	import erm_pkg::*;

	localparam longint unsigned FULL = 64'd360 << ANGLE_FRAC_BITS;
	localparam longint unsigned QTR = 64'd90 << ANGLE_FRAC_BITS;
	localparam longint unsigned EIG = 64'd45 << ANGLE_FRAC_BITS;
	localparam longint unsigned DEN = 64'd180 << ANGLE_FRAC_BITS;

	// offset that makes any 16-bit angle non-negative
	localparam longint unsigned WRAPS = (64'd32768 + FULL - 64'd1) / FULL;
	localparam longint unsigned UMAX = 64'd32767 + WRAPS * FULL;
	localparam int UW = $clog2(UMAX + 64'd1);
	localparam int LF = $clog2(FULL);
	localparam int SH1 = UW + LF;
	localparam longint unsigned M1 = ((64'd1 << SH1) + FULL - 64'd1) / FULL;
	localparam int MW1 = UW + 2;
	localparam int QW1 = $clog2(64'd2 * WRAPS + 64'd2);

	localparam int TW = $clog2(EIG + 64'd1);

	// x = t*PA + floor((t*PB + DEN/2) / DEN)
	localparam longint unsigned PA = PI_Q30 / DEN;
	localparam longint unsigned PB = PI_Q30 % DEN;
	localparam longint unsigned YMAX = (EIG * PB + DEN / 64'd2) >> ANGLE_FRAC_BITS;
	localparam int YW = $clog2(YMAX + 64'd1);
	localparam int SH2 = YW + 8;
	localparam longint unsigned M2 = ((64'd1 << SH2) + 64'd179) / 64'd180;
	localparam int MW2 = YW + 1;

	localparam logic [LF-1:0] Q1C = LF'(QTR);
	localparam logic [LF-1:0] Q2C = LF'(64'd2 * QTR);
	localparam logic [LF-1:0] Q3C = LF'(64'd3 * QTR);
	localparam logic [LF-1:0] EGC = LF'(EIG);

	logic [UW:0]         u_ext;
	logic [UW-1:0]       u_s1;
	logic [UW+MW1-1:0]   p1_s1;
	logic [QW1-1:0]      q1;
	logic [LF-1:0]       m_s2;
	logic [1:0]          quad;
	logic [LF-1:0]       rr;
	logic                swap;
	logic [TW-1:0]       t;
	logic [TW-1:0]       t_s3;
	octant_t             oct_s3, oct_s4, oct_s5;
	logic [29:0]         ta_s4, ta_s5;
	logic [YW-1:0]       yp_s4;
	logic [YW+MW2-1:0]   p2_s5;

	assign u_ext = (UW+1)'(angle) + (UW+1)'(WRAPS * FULL);
	assign q1 = QW1'(p1_s1 >> SH1);

	always_comb begin
		priority if (m_s2 >= Q3C) begin
			quad = 2'd3;
		end else if (m_s2 >= Q2C) begin
			quad = 2'd2;
		end else if (m_s2 >= Q1C) begin
			quad = 2'd1;
		end else begin
			quad = 2'd0;
		end
		rr = LF'(m_s2 - LF'(64'(quad) * QTR));
		swap = (rr > EGC);
		t = swap ? TW'(QTR - 64'(rr)) : TW'(rr);
	end

	always_ff @(posedge clk) begin
		// modulo full turn by reciprocal
		u_s1 <= u_ext[UW-1:0];
		p1_s1 <= (UW+MW1)'(u_ext[UW-1:0] * MW1'(M1));
		m_s2 <= LF'(u_s1 - UW'(64'(q1) * FULL));
		// quadrant and octant fold
		t_s3 <= t;
		oct_s3 <= '{quad: quad, swap: swap};
		// degrees to radians
		ta_s4 <= 30'(64'(t_s3) * PA);
		yp_s4 <= YW'((64'(t_s3) * PB + DEN / 64'd2) >> ANGLE_FRAC_BITS);
		oct_s4 <= oct_s3;
		ta_s5 <= ta_s4;
		p2_s5 <= (YW+MW2)'(yp_s4 * MW2'(M2));
		oct_s5 <= oct_s4;
		x_s6 <= 30'(ta_s5 + 30'(p2_s5 >> SH2));
		oct_s6 <= oct_s5;
	end

endmodule

@@ design/erm_level.sv @@
module erm_level #(
	parameter int LEVEL = 1
) (
	input  logic             clk,
	input  logic [29:0]      x,
	input  logic [29:0]      x2,
	input  logic [30:0]      ps,
	input  logic [30:0]      pc,
	input  erm_pkg::octant_t oct,
	output logic [29:0]      x_s2,
	output logic [29:0]      x2_s2,
	output logic [30:0]      ps_s2,
	output logic [30:0]      pc_s2,
	output erm_pkg::octant_t oct_s2
);
	import erm_pkg::*;

	localparam longint unsigned DS = 64'(2 * LEVEL) * 64'(2 * LEVEL + 1);
	localparam longint unsigned DC = 64'(2 * LEVEL - 1) * 64'(2 * LEVEL);
	localparam int SKS = QF + $clog2(DS);
	localparam int SKC = QF + $clog2(DC);
	localparam longint unsigned MKS = ((64'd1 << SKS) + DS - 64'd1) / DS;
	localparam longint unsigned MKC = ((64'd1 << SKC) + DC - 64'd1) / DC;

	logic [60:0] vs_s1, vc_s1;
	logic [29:0] x_s1, x2_s1;
	octant_t     oct_s1;
	logic [29:0] vs, vc;
	logic [30:0] qs, qc;

	// exact floor division by the series constant
	assign vs = 30'(vs_s1 >> QF);
	assign vc = 30'(vc_s1 >> QF);
	assign qs = 31'((61'(vs) * 61'(MKS)) >> SKS);
	assign qc = 31'((61'(vc) * 61'(MKC)) >> SKC);

	always_ff @(posedge clk) begin
		vs_s1 <= 61'(x2 * ps);
		vc_s1 <= 61'(x2 * pc);
		x_s1 <= x;
		x2_s1 <= x2;
		oct_s1 <= oct;
		ps_s2 <= 31'(Q_ONE) - qs;
		pc_s2 <= 31'(Q_ONE) - qc;
		x_s2 <= x_s1;
		x2_s2 <= x2_s1;
		oct_s2 <= oct_s1;
	end

endmodule

@@ design/erm_lane.sv @@
module erm_lane #(
	parameter int ANGLE_FRAC_BITS = erm_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic signed [15:0] angle,
	output erm_pkg::q30_t      s_s18,
	output erm_pkg::q30_t      c_s18
);
	import erm_pkg::*;

	logic [29:0] x_p;
	octant_t     oct_p;
	logic [59:0] xx_s1;
	logic [29:0] x_s1, x_s2;
	octant_t     oct_s1, oct_s2;
	logic [29:0] x2_s2;

	logic [29:0] xl [0:SERIES_LEVELS];
	logic [29:0] x2l [0:SERIES_LEVELS];
	logic [30:0] psl [0:SERIES_LEVELS];
	logic [30:0] pcl [0:SERIES_LEVELS];
	octant_t     octl [0:SERIES_LEVELS];

	logic [60:0] sp_s17;
	logic [30:0] c0_s17;
	octant_t     oct_s17;
	logic [30:0] s0, sa, ca;
	q30_t        sv, cv;

	erm_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase (
		.clk    (clk),
		.angle  (angle),
		.x_s6   (x_p),
		.oct_s6 (oct_p)
	);

	always_ff @(posedge clk) begin
		xx_s1 <= 60'(x_p * x_p);
		x_s1 <= x_p;
		oct_s1 <= oct_p;
		x2_s2 <= 30'((xx_s1 + 60'(Q_HALF)) >> QF);
		x_s2 <= x_s1;
		oct_s2 <= oct_s1;
	end

	assign xl[0] = x_s2;
	assign x2l[0] = x2_s2;
	assign psl[0] = 31'(Q_ONE);
	assign pcl[0] = 31'(Q_ONE);
	assign octl[0] = oct_s2;

	// Horner levels, highest term first
	for (genvar i = 0; i < SERIES_LEVELS; i++) begin : g_lvl
		erm_level #(.LEVEL(SERIES_LEVELS - i)) u_level (
			.clk    (clk),
			.x      (xl[i]),
			.x2     (x2l[i]),
			.ps     (psl[i]),
			.pc     (pcl[i]),
			.oct    (octl[i]),
			.x_s2   (xl[i+1]),
			.x2_s2  (x2l[i+1]),
			.ps_s2  (psl[i+1]),
			.pc_s2  (pcl[i+1]),
			.oct_s2 (octl[i+1])
		);
	end

	assign s0 = 31'((sp_s17 + 61'(Q_HALF)) >> QF);

	// undo octant fold and quadrant
	always_comb begin
		sa = oct_s17.swap ? c0_s17 : s0;
		ca = oct_s17.swap ? s0 : c0_s17;
		unique case (oct_s17.quad)
			2'd0: begin
				sv = $signed({1'b0, sa});
				cv = $signed({1'b0, ca});
			end
			2'd1: begin
				sv = $signed({1'b0, ca});
				cv = -$signed({1'b0, sa});
			end
			2'd2: begin
				sv = -$signed({1'b0, sa});
				cv = -$signed({1'b0, ca});
			end
			default: begin
				sv = -$signed({1'b0, ca});
				cv = $signed({1'b0, sa});
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sp_s17 <= 61'(xl[SERIES_LEVELS] * psl[SERIES_LEVELS]);
		c0_s17 <= pcl[SERIES_LEVELS];
		oct_s17 <= octl[SERIES_LEVELS];
		s_s18 <= sv;
		c_s18 <= cv;
	end

endmodule

@@ design/erm_merge.sv @@
module erm_merge #(
	parameter int OUT_FRAC_BITS = erm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  erm_pkg::q30_t    sx,
	input  erm_pkg::q30_t    cx,
	input  erm_pkg::q30_t    sy,
	input  erm_pkg::q30_t    cy,
	input  erm_pkg::q30_t    sz,
	input  erm_pkg::q30_t    cz,
	output erm_pkg::matrix_t matrix_s6
);
	import erm_pkg::*;

	localparam int SH = QF - OUT_FRAC_BITS;
	localparam longint unsigned RND = (64'd1 << SH) >> 1;
	localparam longint unsigned LIM = 64'd1 << OUT_FRAC_BITS;

	typedef struct packed {
		logic        neg;
		logic [61:0] mag;
	} rawprod_t;

	function automatic rawprod_t qmul_raw(input q30_t a, input q30_t b);
		logic [30:0] ma, mb;
		rawprod_t    r;
		ma = a[31] ? 31'(-a) : 31'(a);
		mb = b[31] ? 31'(-b) : 31'(b);
		r.neg = a[31] ^ b[31];
		r.mag = 62'(ma) * 62'(mb);
		return r;
	endfunction

	// round half away from zero
	function automatic q30_t qround(input rawprod_t p);
		logic [31:0] m;
		m = 32'((p.mag + 62'(Q_HALF)) >> QF);
		return p.neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [15:0] to_out(input logic signed [32:0] v);
		logic [32:0] mv, u;
		mv = v[32] ? 33'(-v) : 33'(v);
		u = (mv + 33'(RND)) >> SH;
		if (u > 33'(LIM)) begin
			u = 33'(LIM);
		end
		return v[32] ? 16'(-u) : 16'(u);
	endfunction

	// products: 0 czcy 1 szcx 2 szsx 3 czcx 4 czsx 5 cycx 6 cysx 7 szcy 8 czsy 9 szsy
	rawprod_t           r_s1 [0:9];
	q30_t               sx_s1, cx_s1, sy_s1;
	q30_t               p_s2 [0:9];
	q30_t               sx_s2, cx_s2, sy_s2;
	rawprod_t           t_s3 [0:3];
	q30_t               p_s3 [0:7];
	q30_t               sy_s3;
	q30_t               u_s4 [0:3];
	q30_t               p_s4 [0:7];
	q30_t               sy_s4;
	logic signed [32:0] e_s5 [0:8];

	always_ff @(posedge clk) begin
		r_s1[0] <= qmul_raw(cz, cy);
		r_s1[1] <= qmul_raw(sz, cx);
		r_s1[2] <= qmul_raw(sz, sx);
		r_s1[3] <= qmul_raw(cz, cx);
		r_s1[4] <= qmul_raw(cz, sx);
		r_s1[5] <= qmul_raw(cy, cx);
		r_s1[6] <= qmul_raw(cy, sx);
		r_s1[7] <= qmul_raw(sz, cy);
		r_s1[8] <= qmul_raw(cz, sy);
		r_s1[9] <= qmul_raw(sz, sy);
		sx_s1 <= sx;
		cx_s1 <= cx;
		sy_s1 <= sy;

		for (int i = 0; i < 10; i++) begin
			p_s2[i] <= qround(r_s1[i]);
		end
		sx_s2 <= sx_s1;
		cx_s2 <= cx_s1;
		sy_s2 <= sy_s1;

		// triple products, left to right
		t_s3[0] <= qmul_raw(p_s2[8], sx_s2);
		t_s3[1] <= qmul_raw(p_s2[8], cx_s2);
		t_s3[2] <= qmul_raw(p_s2[9], sx_s2);
		t_s3[3] <= qmul_raw(p_s2[9], cx_s2);
		for (int i = 0; i < 8; i++) begin
			p_s3[i] <= p_s2[i];
		end
		sy_s3 <= sy_s2;

		for (int i = 0; i < 4; i++) begin
			u_s4[i] <= qround(t_s3[i]);
		end
		for (int i = 0; i < 8; i++) begin
			p_s4[i] <= p_s3[i];
		end
		sy_s4 <= sy_s3;

		e_s5[0] <= 33'(p_s4[0]);
		e_s5[1] <= 33'(p_s4[1]) + 33'(u_s4[0]);
		e_s5[2] <= 33'(p_s4[2]) - 33'(u_s4[1]);
		e_s5[3] <= -33'(p_s4[7]);
		e_s5[4] <= 33'(p_s4[3]) - 33'(u_s4[2]);
		e_s5[5] <= 33'(p_s4[4]) + 33'(u_s4[3]);
		e_s5[6] <= 33'(sy_s4);
		e_s5[7] <= -33'(p_s4[6]);
		e_s5[8] <= 33'(p_s4[5]);

		matrix_s6.m_r0_c0 <= to_out(e_s5[0]);
		matrix_s6.m_r0_c1 <= to_out(e_s5[1]);
		matrix_s6.m_r0_c2 <= to_out(e_s5[2]);
		matrix_s6.m_r1_c0 <= to_out(e_s5[3]);
		matrix_s6.m_r1_c1 <= to_out(e_s5[4]);
		matrix_s6.m_r1_c2 <= to_out(e_s5[5]);
		matrix_s6.m_r2_c0 <= to_out(e_s5[6]);
		matrix_s6.m_r2_c1 <= to_out(e_s5[7]);
		matrix_s6.m_r2_c2 <= to_out(e_s5[8]);
	end

endmodule

@@ design/euler_rotation_matrix.sv @@
// channel   | ports                 | handshake
// ----------+-----------------------+-------------------------------------------
// input     | angles (angles_t)     | beat taken at clk edge with start && !busy
// result    | matrix (matrix_t)     | done high one cycle, beat taken at its end
//
// Fully pipelined: one beat accepted every cycle, busy is always low.
// The pipeline runs range reduction and phase, then the sine/cosine series
// (two stages per term, seven terms), then the matrix products and output
// rounding. The 31x31 multipliers set the stage depth.
// Reset clears only the valid pipeline; datapath registers run free.
// The receiver cannot stall; results leave on done regardless.
module euler_rotation_matrix #(
	parameter int ANGLE_FRAC_BITS = erm_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = erm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  erm_pkg::angles_t angles,
	output logic             done,
	output erm_pkg::matrix_t matrix
);
	import erm_pkg::*;

	logic [TOTAL_LAT-1:0] vld_q;
	q30_t                 sx, cx, sy, cy, sz, cz;

	// never back-pressures: every cycle can take a beat
	assign busy = 1'b0;

	// one lane per axis, each a full angle-to-sin/cos pipeline
	erm_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_x (
		.clk   (clk),
		.angle (angles.angle_x),
		.s_s18 (sx),
		.c_s18 (cx)
	);

	erm_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_y (
		.clk   (clk),
		.angle (angles.angle_y),
		.s_s18 (sy),
		.c_s18 (cy)
	);

	erm_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_z (
		.clk   (clk),
		.angle (angles.angle_z),
		.s_s18 (sz),
		.c_s18 (cz)
	);

	// combine the three lanes into the nine matrix entries
	erm_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
		.clk       (clk),
		.sx        (sx),
		.cx        (cx),
		.sy        (sy),
		.cy        (cy),
		.sz        (sz),
		.cz        (cz),
		.matrix_s6 (matrix)
	);

	// valid tracks the beat through the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[TOTAL_LAT-1];

`ifndef ASSERT_OFF
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TOTAL_LAT))
		else $error("result strobe without an accepted beat");

	a_beat_comes_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##TOTAL_LAT done)
		else $error("accepted beat produced no result");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (OUT_FRAC_BITS == 14)) |->
		(matrix.m_r2_c2 <= 16'sd16384 && matrix.m_r2_c2 >= -16'sd16384 &&
		 matrix.m_r0_c0 <= 16'sd16384 && matrix.m_r0_c0 >= -16'sd16384))
		else $error("matrix entry beyond unity");
`endif

endmodule

@@ tb/euler_rotation_matrix_tb.sv @@
module euler_rotation_matrix_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import erm_pkg::*;

	// predictor formats, fixed at the block's default parameters
	localparam int ANG_FB = ANGLE_FRAC_BITS_DEF;
	localparam int OUT_FB = OUT_FRAC_BITS_DEF;
	localparam longint DEG = longint'(1) << ANG_FB;
	localparam longint TURN = 360 * DEG;
	localparam longint QUARTER = 90 * DEG;
	localparam longint EIGHTH = 45 * DEG;
	localparam longint HALF = 180 * DEG;
	localparam int TAIL_CYCLES = TOTAL_LAT + 20;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	angles_t angles;
	logic done;
	matrix_t matrix;
	int mismatch_cnt;

	euler_rotation_matrix DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.angles(angles),
		.done(done),
		.matrix(matrix)
	);

	// sine and cosine, Q30, non-negative, of a folded angle in [0, 45] degrees
	function automatic void octant_trig(input longint unsigned t,
			output longint unsigned s, output longint unsigned c);
		longint unsigned ph, ph2, ps, pc;
		ph = (t * PI_Q30 + HALF / 2) / HALF;
		ph2 = (ph * ph + Q_HALF) >> QF;
		ps = Q_ONE;
		pc = Q_ONE;
		for (int n = SERIES_LEVELS; n >= 1; n--) begin
			ps = Q_ONE - ((ph2 * ps) >> QF) / longint'((2 * n) * (2 * n + 1));
			pc = Q_ONE - ((ph2 * pc) >> QF) / longint'((2 * n - 1) * (2 * n));
		end
		s = (ph * ps + Q_HALF) >> QF;
		c = pc;
	endfunction

	// full-circle sine/cosine: wrap, split into quadrant, fold past 45 degrees
	function automatic void angle_trig(input logic signed [15:0] a,
			output longint s, output longint c);
		longint m, r;
		int quad;
		longint unsigned s0, c0;
		m = longint'(a) % TURN;
		if (m < 0)
			m += TURN;
		quad = int'(m / QUARTER);
		r = m % QUARTER;
		if (r <= EIGHTH)
			octant_trig(r, s0, c0);
		else
			octant_trig(QUARTER - r, c0, s0);
		case (quad)
			0: begin s = s0; c = c0; end
			1: begin s = c0; c = -longint'(s0); end
			2: begin s = -longint'(s0); c = -longint'(c0); end
			default: begin s = -longint'(c0); c = s0; end
		endcase
	endfunction

	// Q30 product, half away from zero
	function automatic longint qprod(input longint a, input longint b);
		longint unsigned ma, mb, p;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = (ma * mb + Q_HALF) >> QF;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	// Q30 to output format: round, saturate to +-1, keep 16 bits
	function automatic logic [15:0] to_entry(input longint v);
		longint unsigned u;
		longint res;
		u = (v < 0) ? -v : v;
		if (QF > OUT_FB)
			u = (u + (longint'(1) << (QF - OUT_FB - 1))) >> (QF - OUT_FB);
		if (u > (longint'(1) << OUT_FB))
			u = longint'(1) << OUT_FB;
		res = (v < 0) ? -longint'(u) : longint'(u);
		return res[15:0];
	endfunction

	function automatic matrix_t rotation_of(input angles_t a);
		longint sx, cx, sy, cy, sz, cz, czsy, szsy;
		matrix_t m;
		angle_trig(a.angle_x, sx, cx);
		angle_trig(a.angle_y, sy, cy);
		angle_trig(a.angle_z, sz, cz);
		czsy = qprod(cz, sy);
		szsy = qprod(sz, sy);
		m.m_r0_c0 = to_entry(qprod(cz, cy));
		m.m_r0_c1 = to_entry(qprod(sz, cx) + qprod(czsy, sx));
		m.m_r0_c2 = to_entry(qprod(sz, sx) - qprod(czsy, cx));
		m.m_r1_c0 = to_entry(-qprod(sz, cy));
		m.m_r1_c1 = to_entry(qprod(cz, cx) - qprod(szsy, sx));
		m.m_r1_c2 = to_entry(qprod(cz, sx) + qprod(szsy, cx));
		m.m_r2_c0 = to_entry(sy);
		m.m_r2_c1 = to_entry(-qprod(cy, sx));
		m.m_r2_c2 = to_entry(qprod(cy, cx));
		return m;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatch_cnt++;
	endtask

	// holds the matrices still owed by the block, oldest first
	class matrix_board;
		matrix_t owed[$];

		function void note_angles(angles_t a);
			owed.push_back(rotation_of(a));
		endfunction

		task check_matrix(matrix_t got);
			matrix_t want;
			logic signed [15:0] g[9], w[9];
			if (owed.size() == 0) begin
				report_mismatch("unexpected matrix", 0, 0);
				return;
			end
			want = owed.pop_front();
			g = '{got.m_r0_c0, got.m_r0_c1, got.m_r0_c2, got.m_r1_c0, got.m_r1_c1,
				got.m_r1_c2, got.m_r2_c0, got.m_r2_c1, got.m_r2_c2};
			w = '{want.m_r0_c0, want.m_r0_c1, want.m_r0_c2, want.m_r1_c0, want.m_r1_c1,
				want.m_r1_c2, want.m_r2_c0, want.m_r2_c1, want.m_r2_c2};
			for (int i = 0; i < 9; i++)
				if (g[i] !== w[i])
					report_mismatch($sformatf("m_r%0d_c%0d", i / 3, i % 3),
						int'(g[i]), int'(w[i]));
		endtask
	endclass

	matrix_board board = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// results cannot be held off: take every done beat
	always @(posedge clk)
		if (arst_n && done === 1'b1)
			board.check_matrix(matrix);

	// one beat: optional gap, then hold start until the block takes it
	task automatic send_angles(input angles_t a, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		angles <= a;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_angles(a);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return 16'($urandom());
			1: return 16'($urandom_range(0, 8) * 45 * DEG);
			2: return -16'($urandom_range(0, 8) * 45 * DEG);
			3: return 16'(int'($urandom_range(0, 32)) - 16) + 16'($urandom_range(0, 8) * EIGHTH);
			default: return 16'(int'($urandom_range(0, 46080)) - 23040);
		endcase
	endfunction

	function automatic angles_t mk(int x, int y, int z);
		angles_t a;
		a.angle_x = 16'(x);
		a.angle_y = 16'(y);
		a.angle_z = 16'(z);
		return a;
	endfunction

	initial begin
		angles_t directed[$];
		angles_t a;
		start = 1'b0;
		angles = '0;
		mismatch_cnt = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, field extremes, octant and quadrant edges, wrap past a full turn
		directed = '{mk(0, 0, 0), mk(23040, 23040, 23040), mk(-23040, -23040, -23040),
			mk(32767, -32768, 32767), mk(-32768, 32767, -32768), mk(-1, -1, -1),
			mk(1, 1, 1), mk(2880, 2880, 2880), mk(2881, 2879, -2880),
			mk(5760, 0, 0), mk(0, 5760, 0), mk(0, 0, 5760),
			mk(11520, -5760, 17280), mk(-11520, 17280, -17280), mk(5760, 5760, 5760),
			mk(5759, 5761, 23041), mk(-23041, 8640, 14400), mk(20160, -20160, 2880),
			mk(16'h5555, 16'hAAAA, 16'h7FFF), mk(16'hAAAA, 16'h5555, 16'h8000)};
		foreach (directed[i])
			send_angles(directed[i], 0);

		// let the pipe drain once before the random part
		start <= 1'b0;
		while (board.owed.size() != 0)
			@(posedge clk);

		for (int i = 0; i < 600; i++) begin
			a = mk(int'(rand_angle()), int'(rand_angle()), int'(rand_angle()));
			// stretches of back-to-back beats alternate with random gaps
			send_angles(a, ((i / 64) % 2 == 0) ? 0 : $urandom_range(0, 17));
			if (i == 300) begin
				start <= 1'b0;
				while (board.owed.size() != 0)
					@(posedge clk);
			end
		end
		start <= 1'b0;

		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && board.owed.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end
endmodule

@@ sim.f @@
design/erm_pkg.sv
design/erm_phase.sv
design/erm_level.sv
design/erm_lane.sv
design/erm_merge.sv
design/euler_rotation_matrix.sv
tb/euler_rotation_matrix_tb.sv
